### hdl/nbbo_quote_aggregator_defines.svh
// Assertion macros shared by the NBBO quote aggregator RTL.
`ifndef NBBO_QUOTE_AGGREGATOR_DEFINES_SVH
`define NBBO_QUOTE_AGGREGATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define NQA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define NQA_ASSERT_NEVER(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);
`else
`define NQA_ASSERT(lbl, prop, msg)
`define NQA_ASSERT_NEVER(lbl, prop, msg)
`endif

`endif

### hdl/nqa_pkg.sv
// Types, constants and codes shared by the NBBO quote aggregator.
`default_nettype none
package nqa_pkg;

  localparam int unsigned DEF_EXCHANGES = 32;
  localparam int unsigned DEF_SYMBOLS   = 4096;

  localparam int unsigned TS_W    = 47;
  localparam int unsigned SYM_W_I = 12;
  localparam int unsigned EX_W_I  = 5;
  localparam int unsigned CHR_W   = 8;
  localparam int unsigned PRICE_W = 32;
  localparam int unsigned QSIZE_W = 24;
  localparam int unsigned BSIZE_W = 29;
  localparam int unsigned MASK_W  = 32;

  localparam logic [CHR_W-1:0] CH_C = 8'h43;
  localparam logic [CHR_W-1:0] CH_E = 8'h45;
  localparam logic [CHR_W-1:0] CH_F = 8'h46;
  localparam logic [CHR_W-1:0] CH_I = 8'h49;
  localparam logic [CHR_W-1:0] CH_L = 8'h4C;
  localparam logic [CHR_W-1:0] CH_N = 8'h4E;
  localparam logic [CHR_W-1:0] CH_U = 8'h55;
  localparam logic [CHR_W-1:0] CH_X = 8'h58;
  localparam logic [CHR_W-1:0] CH_Z = 8'h5A;
  localparam logic [CHR_W-1:0] CH_4 = 8'h34;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_UNKNOWN_SRC  = 2'd1,
    ST_INCONSISTENT = 2'd2
  } status_e;

  typedef struct packed {
    logic [TS_W-1:0]    timestamp;
    logic [SYM_W_I-1:0] symbol_index;
    logic [EX_W_I-1:0]  exchange_index;
    logic [CHR_W-1:0]   source_code;
    logic [CHR_W-1:0]   condition_code;
    logic [PRICE_W-1:0] bid_price;
    logic [QSIZE_W-1:0] bid_size;
    logic [PRICE_W-1:0] offer_price;
    logic [QSIZE_W-1:0] offer_size;
  } quote_in_t;

  typedef struct packed {
    logic               changed;
    logic [TS_W-1:0]    quote_time;
    logic [PRICE_W-1:0] best_bid_price;
    logic [BSIZE_W-1:0] best_bid_size;
    logic [PRICE_W-1:0] best_offer_price;
    logic [BSIZE_W-1:0] best_offer_size;
    status_e            status;
  } quote_out_t;

  typedef struct packed {
    logic              clear;
    logic              load;
    logic              eval;
    logic              scan_issue;
    logic [EX_W_I-1:0] scan_idx;
    logic              commit;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic need_scan;
    logic abort;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

### hdl/nbbo_quote_aggregator.sv
// Top level of the NBBO quote aggregator: controller plus datapath.
//
// Input channel in_valid_i/in_ready_o/in_data_i carries one exchange quote
// update per transaction; output channel out_valid_o/out_ready_i/out_data_o
// carries exactly one NBBO result per accepted quote, in order.
// Flow: a quote is accepted in the idle state, its stores are read in the read
// state, the side updates are evaluated in the eval state, and the result is
// registered in the commit state once the output register is free; the block
// takes no new quote until it is back in idle after that commit. When the sole
// contributor of a side leaves, the stored quotes of the symbol are rescanned
// one exchange per cycle before the commit.
// The output register holds one finished result; the block accepts the next
// quote while it waits and stalls before writing back a second result until
// the receiver takes the first.
// After reset the block runs a clearing pass over the quote stores, one entry
// per cycle, over all 2^(clog2(SYMBOLS)+clog2(EXCHANGES)) entries (131072 by
// default), with in_ready_o low throughout.
`default_nettype none
module nbbo_quote_aggregator
  import nqa_pkg::*;
#(
  parameter int unsigned EXCHANGES = DEF_EXCHANGES,
  parameter int unsigned SYMBOLS   = DEF_SYMBOLS
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  quote_in_t  in_data_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output quote_out_t out_data_o
);

  cmd_t  cmd;
  stat_t stat;

  nqa_ctrl #(
    .EXCHANGES(EXCHANGES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  nqa_dp #(
    .EXCHANGES(EXCHANGES),
    .SYMBOLS  (SYMBOLS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

### hdl/nqa_ctrl.sv
// Controller state machine of the NBBO quote aggregator.
`default_nettype none
`include "nbbo_quote_aggregator_defines.svh"
module nqa_ctrl
  import nqa_pkg::*;
#(
  parameter int unsigned EXCHANGES = DEF_EXCHANGES
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  stat_t     stat_i,
  output cmd_t      cmd_o
);

  typedef enum logic [6:0] {
    S_CLEAR    = 7'b0000001,
    S_IDLE     = 7'b0000010,
    S_READ     = 7'b0000100,
    S_EVAL     = 7'b0001000,
    S_SCAN     = 7'b0010000,
    S_SCAN_END = 7'b0100000,
    S_COMMIT   = 7'b1000000
  } state_e;

  localparam logic [EX_W_I-1:0] LAST_EX = EX_W_I'(EXCHANGES - 1);

  state_e state_q, state_d;
  logic [EX_W_I-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clear_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_READ;
        end
      end
      S_READ: state_d = S_EVAL;
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        cnt_d = '0;
        if (!stat_i.abort && stat_i.need_scan) state_d = S_SCAN;
        else state_d = S_COMMIT;
      end
      S_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        cmd_o.scan_idx   = cnt_q;
        if (cnt_q == LAST_EX) state_d = S_SCAN_END;
        else cnt_d = cnt_q + 1'b1;
      end
      S_SCAN_END: state_d = S_COMMIT;
      S_COMMIT: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  `NQA_ASSERT(a_ready_after_clear, in_ready_o |-> stat_i.clear_done, "ready before clear")
  `NQA_ASSERT(a_commit_free, cmd_o.commit |-> stat_i.out_free, "commit into full output")
  `NQA_ASSERT(a_scan_range, cmd_o.scan_issue |-> (cmd_o.scan_idx <= LAST_EX), "scan range")
  `NQA_ASSERT(a_load_read, cmd_o.load |=> (state_q == S_READ), "load not followed by read")

endmodule
`default_nettype wire

### hdl/nqa_dp.sv
// Datapath of the NBBO quote aggregator: quote stores, side update and rescan.
`default_nettype none
module nqa_dp
  import nqa_pkg::*;
#(
  parameter int unsigned EXCHANGES = DEF_EXCHANGES,
  parameter int unsigned SYMBOLS   = DEF_SYMBOLS
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  quote_in_t in_data_i,
  input  cmd_t      cmd_i,
  output stat_t     stat_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output quote_out_t out_data_o
);

  localparam int unsigned EX_W  = $clog2(EXCHANGES);
  localparam int unsigned SYM_W = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int unsigned AW    = SYM_W + EX_W;
  localparam int unsigned EX_DEPTH   = 1 << AW;
  localparam int unsigned BEST_DEPTH = 1 << SYM_W;
  localparam logic [PRICE_W-1:0] BID_EMPTY = '0;
  localparam logic [PRICE_W-1:0] OFF_EMPTY = '1;

  typedef struct packed {
    logic               set;
    logic [PRICE_W-1:0] price;
    logic [QSIZE_W-1:0] size;
  } entry_t;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [BSIZE_W-1:0] size;
    logic [MASK_W-1:0]  mask;
  } best_t;

  typedef struct packed {
    best_t bid;
    best_t off;
  } best_row_t;

  typedef struct packed {
    logic  rescan;
    logic  err;
    best_t best;
  } side_res_t;

  localparam best_row_t BEST_RESET = '{
    bid: '{price: BID_EMPTY, size: '0, mask: '0},
    off: '{price: OFF_EMPTY, size: '0, mask: '0}};

  function automatic logic better(input logic is_bid, input logic [PRICE_W-1:0] a,
                                  input logic [PRICE_W-1:0] b);
    return is_bid ? (a > b) : (a < b);
  endfunction

  function automatic side_res_t side_eval(input logic is_bid, input best_t cb,
                                          input entry_t cur, input entry_t nq,
                                          input logic [EX_W_I-1:0] ex);
    logic [MASK_W-1:0]  bit_m;
    logic [MASK_W-1:0]  mask;
    logic [PRICE_W-1:0] bp;
    logic [PRICE_W-1:0] empty;
    logic signed [31:0] sz;
    logic signed [31:0] ns;
    logic signed [31:0] cs;
    logic contrib;
    logic many;
    logic leave;
    side_res_t r;
    empty   = is_bid ? BID_EMPTY : OFF_EMPTY;
    bit_m   = MASK_W'(1) << ex;
    mask    = cb.mask;
    bp      = cb.price;
    sz      = $signed({3'b000, cb.size});
    ns      = $signed({8'h00, nq.size});
    cs      = $signed({8'h00, cur.size});
    contrib = (mask & bit_m) != '0;
    many    = (mask & (mask - 1'b1)) != '0;
    leave   = 1'b0;
    r       = '0;
    if (nq.set) begin
      if (better(is_bid, nq.price, bp)) begin
        mask = bit_m;
        bp   = nq.price;
        sz   = ns;
      end else if (nq.price == bp) begin
        if (contrib) sz = sz + ns - cs;
        else begin
          mask = mask | bit_m;
          sz   = sz + ns;
        end
      end else if (contrib) leave = 1'b1;
      else if (mask == '0) r.err = 1'b1;
    end else if (contrib) leave = 1'b1;
    if (leave) begin
      if (many) begin
        sz   = sz - cs;
        mask = mask & ~bit_m;
      end else r.rescan = 1'b1;
    end
    if (!r.rescan && !r.err) begin
      if (sz == 32'sd0) bp = empty;
      else if (sz < 32'sd0 || sz > 32'sh1FFFFFFF) r.err = 1'b1;
    end
    r.best.price = bp;
    r.best.size  = sz[BSIZE_W-1:0];
    r.best.mask  = mask;
    return r;
  endfunction

  function automatic best_t scan_step(input logic is_bid, input best_t acc, input entry_t q,
                                      input logic [EX_W_I-1:0] idx);
    best_t r;
    r = acc;
    if (q.set) begin
      if (better(is_bid, q.price, acc.price)) begin
        r.mask  = MASK_W'(1) << idx;
        r.price = q.price;
        r.size  = BSIZE_W'(q.size);
      end else if (q.price == acc.price) begin
        r.mask = acc.mask | (MASK_W'(1) << idx);
        r.size = acc.size + BSIZE_W'(q.size);
      end
    end
    return r;
  endfunction

  entry_t    bid_mem [EX_DEPTH];
  entry_t    off_mem [EX_DEPTH];
  best_row_t best_mem [BEST_DEPTH];

  quote_in_t item_q;
  entry_t    bid_rd_q, off_rd_q;
  best_row_t best_rd_q;
  logic [AW:0] clr_q;
  best_t     bres_q, ores_q;
  logic      bresc_q, oresc_q, err_q;
  logic      acc_vld_q;
  logic [EX_W_I-1:0] acc_idx_q;
  logic      out_valid_q;
  quote_out_t out_q;

  logic [16:0] sym_ext;
  logic [SYM_W-1:0] sym_a;
  logic sym_ok, ex_ok;
  logic cta_bad, utp_bad, valid_c;
  logic bid_set, off_set;
  status_e code;
  entry_t nb, no;
  side_res_t bev, oev;
  logic [EX_W-1:0] rd_ex;
  logic [AW-1:0] ex_ra, ex_wa;
  logic [SYM_W-1:0] best_wa;
  logic clearing, commit_ok, ex_we;
  entry_t qb, qo;
  best_row_t old_row, new_row;

  assign sym_ext = 17'(item_q.symbol_index);
  assign sym_a   = sym_ext[SYM_W-1:0];
  assign sym_ok  = sym_ext < 17'(SYMBOLS);
  assign ex_ok   = 6'(item_q.exchange_index) < 6'(EXCHANGES);

  assign cta_bad = item_q.condition_code inside {CH_C, CH_L, CH_N, CH_U, CH_4};
  assign utp_bad = item_q.condition_code inside {CH_F, CH_I, CH_L, CH_N, CH_U, CH_X,
                                                  CH_Z, CH_4};

  always_comb begin
    code    = ST_OK;
    valid_c = 1'b0;
    bid_set = 1'b0;
    off_set = 1'b0;
    case (item_q.source_code)
      CH_C: begin
        valid_c = !cta_bad;
        bid_set = valid_c && item_q.condition_code != CH_E && item_q.bid_size != '0;
        off_set = valid_c && item_q.condition_code != CH_F && item_q.offer_size != '0;
      end
      CH_N: begin
        valid_c = !utp_bad;
        bid_set = valid_c && item_q.bid_size != '0;
        off_set = valid_c && item_q.offer_size != '0;
      end
      default: code = ST_UNKNOWN_SRC;
    endcase
    if (code == ST_OK && (!sym_ok || !ex_ok)) code = ST_INCONSISTENT;
  end

  assign nb = '{set: bid_set, price: item_q.bid_price, size: item_q.bid_size};
  assign no = '{set: off_set, price: item_q.offer_price, size: item_q.offer_size};

  assign bev = side_eval(1'b1, best_rd_q.bid, bid_rd_q, nb, item_q.exchange_index);
  assign oev = side_eval(1'b0, best_rd_q.off, off_rd_q, no, item_q.exchange_index);

  assign clearing  = cmd_i.clear && !clr_q[AW];
  assign commit_ok = cmd_i.commit && code == ST_OK && !err_q;
  assign ex_we     = clearing || commit_ok;

  assign rd_ex   = cmd_i.scan_issue ? cmd_i.scan_idx[EX_W-1:0]
                                    : item_q.exchange_index[EX_W-1:0];
  assign ex_ra   = {sym_a, rd_ex};
  assign ex_wa   = clearing ? clr_q[AW-1:0] : {sym_a, item_q.exchange_index[EX_W-1:0]};
  assign best_wa = clearing ? clr_q[AW-1:EX_W] : sym_a;
  assign new_row = '{bid: bres_q, off: ores_q};
  assign old_row = sym_ok ? best_rd_q : BEST_RESET;

  always_ff @(posedge clk_i) begin
    if (ex_we) begin
      bid_mem[ex_wa] <= clearing ? entry_t'('0) : nb;
      off_mem[ex_wa] <= clearing ? entry_t'('0) : no;
      best_mem[best_wa] <= clearing ? BEST_RESET : new_row;
    end
    bid_rd_q  <= bid_mem[ex_ra];
    off_rd_q  <= off_mem[ex_ra];
    best_rd_q <= best_mem[sym_a];
  end

  assign qb = (acc_idx_q == item_q.exchange_index) ? nb : bid_rd_q;
  assign qo = (acc_idx_q == item_q.exchange_index) ? no : off_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_data_i;
    if (cmd_i.eval) begin
      bresc_q <= bev.rescan;
      oresc_q <= oev.rescan;
      err_q   <= bev.err || oev.err;
      bres_q  <= bev.rescan ? BEST_RESET.bid : bev.best;
      ores_q  <= oev.rescan ? BEST_RESET.off : oev.best;
    end else if (acc_vld_q) begin
      if (bresc_q) bres_q <= scan_step(1'b1, bres_q, qb, acc_idx_q);
      if (oresc_q) ores_q <= scan_step(1'b0, ores_q, qo, acc_idx_q);
    end
    acc_idx_q <= cmd_i.scan_idx;
    if (cmd_i.commit) begin
      out_q.quote_time <= item_q.timestamp;
      if (commit_ok) begin
        out_q.changed <= (bres_q.price != best_rd_q.bid.price) ||
                         (bres_q.size  != best_rd_q.bid.size)  ||
                         (ores_q.price != best_rd_q.off.price) ||
                         (ores_q.size  != best_rd_q.off.size);
        out_q.best_bid_price   <= bres_q.price;
        out_q.best_bid_size    <= bres_q.size;
        out_q.best_offer_price <= ores_q.price;
        out_q.best_offer_size  <= ores_q.size;
        out_q.status           <= ST_OK;
      end else begin
        out_q.changed          <= 1'b0;
        out_q.best_bid_price   <= old_row.bid.price;
        out_q.best_bid_size    <= old_row.bid.size;
        out_q.best_offer_price <= old_row.off.price;
        out_q.best_offer_size  <= old_row.off.size;
        out_q.status           <= (code != ST_OK) ? code : ST_INCONSISTENT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      acc_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (clearing) clr_q <= clr_q + 1'b1;
      acc_vld_q <= cmd_i.scan_issue;
      if (cmd_i.commit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign stat_o.clear_done = clr_q[AW];
  assign stat_o.need_scan  = bev.rescan || oev.rescan;
  assign stat_o.abort      = code != ST_OK || bev.err || oev.err;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire
